@@ hdl/nau_pkg.sv @@
// Shared types, register codes and constant functions for the activation unit.
// No dependencies; imported by nau_div and neural_activation_unit.
`timescale 1ns / 1ps
`default_nettype none

package nau_pkg;

  localparam int unsigned SAMPLE_W           = 16;
  localparam int unsigned MODE_W             = 3;
  localparam int unsigned PADDR_W            = 3;
  localparam int unsigned PDATA_W            = 32;
  localparam int unsigned FRAC_BITS_DEF      = 12;
  localparam int unsigned EXP_TABLE_BITS_DEF = 8;
  localparam int unsigned DIV_STEPS          = 4;
  localparam int unsigned SERIES_TERMS       = 24;

  // register index, taken from paddr[2]
  localparam logic REG_MODE = 1'b0;

  localparam logic [MODE_W-1:0] MODE_IDENTITY = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SIGMOID  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TANH     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RELU     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LEAKY    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_RESET    = MODE_RELU;

  localparam longint unsigned LOG2E_Q30 = 64'd1549082005;
  localparam longint unsigned LEAKY_Q30 = 64'd10737418;
  localparam longint unsigned LN2_Q32   = 64'd2977044472;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic                neg;
    logic [SAMPLE_W-1:0] simple;
  } side_t;

  // Q30 constant rounded half up to f fraction bits
  function automatic longint unsigned q30_to_qf(longint unsigned v, int unsigned f);
    return (v + (64'd1 << (29 - f))) >> (30 - f);
  endfunction

  // shift-subtract quotient, used only on elaboration-time constants
  function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // 2^-(idx / 2^tbits) in Q fbits, Taylor series of exp(-x) in Q32
  function automatic logic [31:0] exp_rom_entry(int unsigned idx, int unsigned tbits,
                                                int unsigned fbits);
    longint unsigned x;
    longint unsigned term;
    longint          acc;
    x    = (longint'(idx) * LN2_Q32) >> tbits;
    term = 64'd1 << 32;
    acc  = longint'(64'd1 << 32);
    for (int n = 1; n <= int'(SERIES_TERMS); n++) begin
      term = div_u64((term * x) >> 32, 64'(n));
      if ((n & 1) != 0) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    return 32'((longint'(acc) + (64'd1 << (31 - fbits))) >> (32 - fbits));
  endfunction

endpackage

`default_nettype wire

@@ hdl/nau_div.sv @@
// Pipelined restoring divider: floor(2^(2F) / den), DIV_STEPS quotient bits per stage.
// Sideband rides along with each request. Depends on nau_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nau_div
  import nau_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 vld_i,
  input  wire side_t                side_i,
  input  wire logic [FRAC_BITS+1:0] den_i,
  output logic                      vld_o,
  output side_t                     side_o,
  output logic [FRAC_BITS:0]        quo_o
);

  localparam int unsigned QW   = FRAC_BITS + 1;
  localparam int unsigned NSTG = (QW + DIV_STEPS - 1) / DIV_STEPS;
  localparam logic [FRAC_BITS:0] REM_INIT = (FRAC_BITS+1)'(1) << (FRAC_BITS - 1);

  logic [NSTG-1:0]      vld_q;
  logic [FRAC_BITS:0]   rem_q [NSTG];
  logic [FRAC_BITS:0]   quo_q [NSTG];
  logic [FRAC_BITS+1:0] den_q [NSTG];
  side_t                side_q [NSTG];
  logic [FRAC_BITS:0]   rem_d [NSTG];
  logic [FRAC_BITS:0]   quo_d [NSTG];

  always_comb begin
    logic [FRAC_BITS:0]   r;
    logic [FRAC_BITS:0]   qv;
    logic [FRAC_BITS+1:0] dv;
    logic [FRAC_BITS+1:0] sh;
    for (int g = 0; g < int'(NSTG); g++) begin
      if (g == 0) begin
        r  = REM_INIT;
        qv = '0;
        dv = den_i;
      end else begin
        r  = rem_q[g-1];
        qv = quo_q[g-1];
        dv = den_q[g-1];
      end
      for (int i = 0; i < int'(DIV_STEPS); i++) begin
        if (g * int'(DIV_STEPS) + i < int'(QW)) begin
          sh = {r, 1'b0};
          if (sh >= dv) begin
            r  = (FRAC_BITS+1)'(sh - dv);
            qv = {qv[FRAC_BITS-1:0], 1'b1};
          end else begin
            r  = sh[FRAC_BITS:0];
            qv = {qv[FRAC_BITS-1:0], 1'b0};
          end
        end
      end
      rem_d[g] = r;
      quo_d[g] = qv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NSTG-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < int'(NSTG); g++) begin
      rem_q[g] <= rem_d[g];
      quo_q[g] <= quo_d[g];
      if (g == 0) begin
        den_q[g]  <= den_i;
        side_q[g] <= side_i;
      end else begin
        den_q[g]  <= den_q[g-1];
        side_q[g] <= side_q[g-1];
      end
    end
  end

  assign vld_o  = vld_q[NSTG-1];
  assign side_o = side_q[NSTG-1];
  assign quo_o  = quo_q[NSTG-1];

endmodule

`default_nettype wire

@@ hdl/neural_activation_unit.sv @@
// Top level of the activation unit: APB mode register, exp pipeline, output stage.
// Depends on nau_pkg and nau_div.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//   A sample is taken on sample_i at each rising edge where start_i is high and
//   busy_o is low. busy_o stays low, so a new sample may enter every cycle.
//   Each sample yields one activation on activation_o, marked by done_o for one
//   cycle; the receiver must take it then.
//   Throughput is one request per cycle.
//   Stages: input register, |z|*log2(e) multiply, exp ROM and shift, then the
//   reciprocal divider with four quotient bits per stage, then the output mux.
//   Results leave in request order.
//   The mode register (APB, offset 0) picks identity, sigmoid, tanh, relu or
//   leaky relu; codes 5..7 act as relu. Write it only while no request is in flight.
//   Reset clears the pipeline valids and sets mode to relu.

module neural_activation_unit
  import nau_pkg::*;
#(
  parameter int unsigned FRAC_BITS      = FRAC_BITS_DEF,
  parameter int unsigned EXP_TABLE_BITS = EXP_TABLE_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic signed [SAMPLE_W-1:0] sample_i,
  output logic                            busy_o,
  output logic                            done_o,
  output logic signed [SAMPLE_W-1:0]      activation_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [PADDR_W-1:0]         paddr,
  input  wire logic [PDATA_W-1:0]         pwdata,
  output logic [PDATA_W-1:0]              prdata,
  output logic                            pready
);

  localparam int unsigned TABLE_SIZE = 1 << EXP_TABLE_BITS;
  localparam int unsigned NSTG = (FRAC_BITS + 1 + DIV_STEPS - 1) / DIV_STEPS;
  localparam int unsigned LAT  = 4 + NSTG;
  localparam logic [FRAC_BITS:0]   LOG2E_Q = (FRAC_BITS+1)'(q30_to_qf(LOG2E_Q30, FRAC_BITS));
  localparam logic [FRAC_BITS-1:0] LEAKY_Q = FRAC_BITS'(q30_to_qf(LEAKY_Q30, FRAC_BITS));
  localparam logic [FRAC_BITS:0]   ONE_F   = (FRAC_BITS+1)'(1) << FRAC_BITS;
  localparam logic signed [SAMPLE_W-1:0] ONE_S = SAMPLE_W'(ONE_F);

  // config
  logic [MODE_W-1:0] mode_q;
  logic              wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MODE) ? PDATA_W'(mode_q) : '0;
  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RESET;
    end else if (wr_en && paddr[2] == REG_MODE) begin
      mode_q <= pwdata[MODE_W-1:0];
    end
  end

  // exp ROM
  logic [FRAC_BITS:0] exp_rom [TABLE_SIZE];

  for (genvar gi = 0; gi < TABLE_SIZE; gi++) begin : g_rom
    localparam logic [FRAC_BITS:0] ENTRY =
      (FRAC_BITS+1)'(exp_rom_entry(gi, EXP_TABLE_BITS, FRAC_BITS));
    assign exp_rom[gi] = ENTRY;
  end

  // stage 0: input register
  logic                       s0_vld_q;
  logic signed [SAMPLE_W-1:0] s0_sample_q;
  logic [MODE_W-1:0]          s0_mode_q;

  // stage 1: scaled magnitude
  logic                s1_vld_q;
  logic [16:0]         s1_t_q;
  side_t               s1_side_q;
  logic [SAMPLE_W-1:0] mag16;
  logic [16:0]         mag17;
  logic [FRAC_BITS+16:0] prod;
  logic [FRAC_BITS+16:0] lprod;
  logic [SAMPLE_W-1:0] leaky_mag;
  side_t               s1_side_d;

  // stage 2: divider operand
  logic                 s2_vld_q;
  logic [FRAC_BITS+1:0] s2_den_q;
  side_t                s2_side_q;
  logic [31:0]          k_ext;
  logic [FRAC_BITS-1:0] frac;
  logic [EXP_TABLE_BITS-1:0] rom_idx;
  logic [FRAC_BITS:0]   rom_val;
  logic [FRAC_BITS:0]   e_val;
  logic [FRAC_BITS+1:0] den_d;

  // divider and output
  logic                div_vld;
  side_t               div_side;
  logic [FRAC_BITS:0]  div_quo;
  logic [FRAC_BITS:0]  tanh_m;
  logic [SAMPLE_W-1:0] act_d;
  logic                done_q;
  logic [SAMPLE_W-1:0] act_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      s0_vld_q <= start_i && !busy_o;
      s1_vld_q <= s0_vld_q;
      s2_vld_q <= s1_vld_q;
      done_q   <= div_vld;
    end
  end

  always_comb begin
    mag16 = s0_sample_q[SAMPLE_W-1] ? (~s0_sample_q + 16'd1) : s0_sample_q;
    mag17 = (s0_mode_q == MODE_TANH) ? {mag16, 1'b0} : {1'b0, mag16};
    prod  = (FRAC_BITS+17)'(mag17) * (FRAC_BITS+17)'(LOG2E_Q);
    lprod = (FRAC_BITS+17)'(mag16) * (FRAC_BITS+17)'(LEAKY_Q)
          + (FRAC_BITS+17)'(ONE_F - 1'b1);
    leaky_mag = lprod[FRAC_BITS+15:FRAC_BITS];
    s1_side_d.mode = s0_mode_q;
    s1_side_d.neg  = s0_sample_q[SAMPLE_W-1];
    case (s0_mode_q)
      MODE_IDENTITY: s1_side_d.simple = s0_sample_q;
      MODE_LEAKY:    s1_side_d.simple = s0_sample_q[SAMPLE_W-1] ?
                                        (16'd0 - leaky_mag) : s0_sample_q;
      default:       s1_side_d.simple = s0_sample_q[SAMPLE_W-1] ? '0 : s0_sample_q;
    endcase
  end

  assign frac = s1_t_q[FRAC_BITS-1:0];

  if (FRAC_BITS >= EXP_TABLE_BITS) begin : g_idx_down
    assign rom_idx = frac[FRAC_BITS-1 -: EXP_TABLE_BITS];
  end else begin : g_idx_up
    assign rom_idx = {frac, {(EXP_TABLE_BITS-FRAC_BITS){1'b0}}};
  end

  always_comb begin
    k_ext   = 32'(s1_t_q >> FRAC_BITS);
    rom_val = exp_rom[rom_idx];
    e_val   = (k_ext >= 32'd16) ? '0 : (rom_val >> k_ext[3:0]);
    den_d   = (FRAC_BITS+2)'(ONE_F) + (FRAC_BITS+2)'(e_val);
  end

  always_ff @(posedge clk_i) begin
    s0_sample_q <= sample_i;
    s0_mode_q   <= mode_q;
    s1_t_q      <= prod[FRAC_BITS+16:FRAC_BITS];
    s1_side_q   <= s1_side_d;
    s2_den_q    <= den_d;
    s2_side_q   <= s1_side_q;
    act_q       <= act_d;
  end

  nau_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (s2_vld_q),
    .side_i(s2_side_q),
    .den_i (s2_den_q),
    .vld_o (div_vld),
    .side_o(div_side),
    .quo_o (div_quo)
  );

  always_comb begin
    tanh_m = (FRAC_BITS+1)'({div_quo, 1'b0} - (FRAC_BITS+2)'(ONE_F));
    case (div_side.mode)
      MODE_SIGMOID: act_d = div_side.neg ? SAMPLE_W'(ONE_F - div_quo) : SAMPLE_W'(div_quo);
      MODE_TANH:    act_d = div_side.neg ? (16'd0 - SAMPLE_W'(tanh_m)) : SAMPLE_W'(tanh_m);
      default:      act_d = div_side.simple;
    endcase
  end

  assign done_o       = done_q;
  assign activation_o = act_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##LAT done_o)
    else $error("request did not complete at the expected latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LAT))
    else $error("result without a matching request");

  a_sigmoid_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_vld && div_side.mode == MODE_SIGMOID |=> !activation_o[SAMPLE_W-1] &&
    activation_o <= ONE_S)
    else $error("sigmoid result out of range");

  a_tanh_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_vld && div_side.mode == MODE_TANH |=> activation_o <= ONE_S &&
    activation_o >= -ONE_S)
    else $error("tanh result out of range");

  a_relu_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_vld && div_side.mode == MODE_RELU |=> !activation_o[SAMPLE_W-1])
    else $error("relu result negative");

endmodule

`default_nettype wire

@@ test/tb_neural_activation_unit.sv @@
// Self-checking testbench for neural_activation_unit: APB mode writes with readback,
// directed corner samples, then random samples in every mode code, gapped and back-to-back.
// Depends on nau_pkg and the neural_activation_unit RTL.
`timescale 1ns / 1ps

module tb_neural_activation_unit;
  import nau_pkg::*;

  localparam int unsigned FRAC    = FRAC_BITS_DEF;
  localparam int unsigned TBITS   = EXP_TABLE_BITS_DEF;
  localparam int unsigned PIPE_LAT = 4 + (FRAC + 1 + 3) / 4;
  localparam longint ONE_Q = longint'(1) << FRAC;
  localparam longint unsigned LOG2E_Q = (LOG2E_Q30 + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
  localparam longint unsigned LEAKY_Q = (LEAKY_Q30 + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
  localparam logic [PADDR_W-1:0] ADDR_MODE = {REG_MODE, 2'b00};
  // spare code, decodes as relu
  localparam logic [MODE_W-1:0] MODE_SPARE = 3'd7;
  localparam int ITEMS_PER_MODE = 58;

  typedef struct {
    logic [MODE_W-1:0]          mode;
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [SAMPLE_W-1:0] activation;
  } expected_t;

  class activation_checker;
    logic [MODE_W-1:0] mode;
    longint unsigned   exp_table[1 << TBITS];
    expected_t         pending_activations[$];
    int                errors;
    int                accepted;
    int                checked;

    function new();
      longint unsigned x;
      longint unsigned term;
      longint          acc;
      mode     = MODE_RESET;
      errors   = 0;
      accepted = 0;
      checked  = 0;
      // 2^-(i/2^T) via exp(-i*ln2/2^T), Taylor series in Q32
      for (int i = 0; i < (1 << TBITS); i++) begin
        x    = (longint'(i) * LN2_Q32) >> TBITS;
        term = 64'd1 << 32;
        acc  = longint'(64'd1 << 32);
        for (int n = 1; n <= 24; n++) begin
          term = ((term * x) >> 32) / longint'(n);
          if (n % 2 == 1) acc = acc - longint'(term);
          else acc = acc + longint'(term);
        end
        if (acc < 0) acc = 0;
        exp_table[i] = (longint'(acc) + (64'd1 << (31 - FRAC))) >> (32 - FRAC);
      end
    endfunction

    function longint unsigned sigmoid_of_mag(longint unsigned a);
      longint unsigned t;
      longint unsigned k;
      longint unsigned e;
      t = (a * LOG2E_Q) >> FRAC;
      k = t >> FRAC;
      e = (k >= 16) ? 64'd0 : exp_table[(t & (ONE_Q - 1)) >> (FRAC - TBITS)] >> k;
      return (64'd1 << (2 * FRAC)) / (longint'(ONE_Q) + e);
    endfunction

    function logic signed [SAMPLE_W-1:0] predict_activation(logic signed [SAMPLE_W-1:0] s);
      longint          z;
      longint unsigned a;
      longint          r;
      z = s;
      a = (z < 0) ? -z : z;
      case (mode)
        MODE_IDENTITY: r = z;
        MODE_SIGMOID: begin
          r = longint'(sigmoid_of_mag(a));
          if (z < 0) r = ONE_Q - r;
        end
        MODE_TANH: begin
          r = 2 * longint'(sigmoid_of_mag(2 * a)) - ONE_Q;
          if (z < 0) r = -r;
        end
        MODE_LEAKY: r = (z >= 0) ? z : -longint'((a * LEAKY_Q + longint'(ONE_Q) - 1) >> FRAC);
        default: r = (z >= 0) ? z : 0;
      endcase
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[SAMPLE_W-1:0];
    endfunction

    function void report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endfunction

    function void note_request(logic signed [SAMPLE_W-1:0] s);
      expected_t e;
      e.mode       = mode;
      e.sample     = s;
      e.activation = predict_activation(s);
      pending_activations.push_back(e);
      accepted++;
    endfunction

    function void check_result(logic signed [SAMPLE_W-1:0] got);
      expected_t e;
      if (pending_activations.size() == 0) begin
        report($sformatf("activation %0d with no request outstanding", got));
        return;
      end
      e = pending_activations.pop_front();
      checked++;
      if (got !== e.activation)
        report($sformatf("mode %0d sample %0d: activation %0d, expected %0d",
                         e.mode, e.sample, got, e.activation));
    endfunction

    function void flush_missing();
      foreach (pending_activations[i])
        report($sformatf("mode %0d sample %0d: no activation returned",
                         pending_activations[i].mode, pending_activations[i].sample));
      pending_activations.delete();
    endfunction

    function int outstanding();
      return pending_activations.size();
    endfunction
  endclass

  logic                       clk_i    = 1'b0;
  logic                       rst_ni   = 1'b0;
  logic                       start_i  = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_i = '0;
  logic                       busy_o;
  logic                       done_o;
  logic signed [SAMPLE_W-1:0] activation_o;
  logic                       psel     = 1'b0;
  logic                       penable  = 1'b0;
  logic                       pwrite   = 1'b0;
  logic [PADDR_W-1:0]         paddr    = '0;
  logic [PDATA_W-1:0]         pwdata   = '0;
  logic [PDATA_W-1:0]         prdata;
  logic                       pready;

  activation_checker sb;

  neural_activation_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .sample_i    (sample_i),
    .busy_o      (busy_o),
    .done_o      (done_o),
    .activation_o(activation_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && sb != null) begin
      if (start_i && !busy_o) sb.note_request(sample_i);
      if (done_o) sb.check_result(activation_o);
    end
  end

  // tasks start and end just after a rising edge
  task automatic check_mode_readback(input logic [MODE_W-1:0] want);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    paddr   <= ADDR_MODE;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[MODE_W-1:0] !== want)
      sb.report($sformatf("mode readback %0d, expected %0d", prdata[MODE_W-1:0], want));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_mode(input logic [MODE_W-1:0] m);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= ADDR_MODE;
    pwdata  <= {(PDATA_W - MODE_W)'($urandom), m};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.mode = m;
    @(posedge clk_i);
    check_mode_readback(m);
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input int idle_pct);
    while (int'($urandom_range(99)) < idle_pct) begin
      start_i  <= 1'b0;
      sample_i <= SAMPLE_W'($urandom);
      @(posedge clk_i);
    end
    start_i  <= 1'b1;
    sample_i <= s;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic drain_results();
    int waited = 0;
    start_i <= 1'b0;
    do begin
      @(posedge clk_i);
      waited++;
    end while (sb.outstanding() > 0 && waited < 64);
    if (sb.outstanding() > 0) sb.flush_missing();
    repeat (PIPE_LAT + 2) @(posedge clk_i);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0, 1, 2, 3: return SAMPLE_W'($urandom);
      4, 5, 6, 7: return SAMPLE_W'(int'($urandom_range(32767)) - 16384);
      8: return SAMPLE_W'(int'($urandom_range(1023)) - 512);
      default: begin
        case ($urandom_range(5))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sh0000;
          3: return -16'sd1;
          4: return 16'sd1;
          default: return 16'sd4096;
        endcase
      end
    endcase
  endfunction

  initial begin
    logic [MODE_W-1:0]          corner_modes[6];
    logic signed [SAMPLE_W-1:0] corner_samples[4];
    int                         idle_pcts[3];
    sb = new();
    corner_modes   = '{MODE_RELU, MODE_IDENTITY, MODE_SIGMOID, MODE_TANH, MODE_LEAKY,
                       MODE_SPARE};
    corner_samples = '{16'sh8000, 16'sh7fff, 16'sh0000, -16'sd1};
    idle_pcts      = '{10, 51, 0};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_mode_readback(MODE_RESET);
    @(posedge clk_i);

    // corners in the reset mode first, then in each function and a spare code
    foreach (corner_modes[i]) begin
      if (i > 0) write_mode(corner_modes[i]);
      foreach (corner_samples[j]) send_sample(corner_samples[j], 0);
      drain_results();
    end

    foreach (idle_pcts[p]) begin
      for (int m = 0; m < (1 << MODE_W); m++) begin
        write_mode(MODE_W'(m));
        for (int n = 0; n < ITEMS_PER_MODE; n++) begin
          if (n == ITEMS_PER_MODE / 2 && $urandom_range(3) == 0) drain_results();
          send_sample(pick_sample(), idle_pcts[p]);
        end
        drain_results();
      end
    end

    repeat (PIPE_LAT + 4) @(posedge clk_i);
    $display("Checked %0d of %0d requests over all eight mode codes, corner samples included,",
             sb.checked, sb.accepted);
    $display("with sender gaps of 10%% and 51%% and back-to-back; %0d mismatches.", sb.errors);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb_neural_activation_unit passed");
    end else begin
      $display("tb_neural_activation_unit failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("tb_neural_activation_unit failed");
    $finish;
  end

endmodule
